// ===== rtl/ipv4dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Widths, character codes and limits shared by the dotted-quad parser files.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

   // payload widths
   localparam int CHAR_W  = 8;
   localparam int ADDR_W  = 32;
   localparam int OCTET_W = 10;

   // parse limits
   localparam logic [OCTET_W-1:0] OCTET_MAX  = 10'd255;
   localparam logic [1:0]         MAX_DIGITS = 2'd3;
   localparam logic [1:0]         LAST_OCTET = 2'd3;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

// ===== rtl/ipv4dq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_req_if
// Character channel: one text byte per transfer with an end-of-text mark.
// ----------------------------------------------------------------------------
interface ipv4dq_req_if import ipv4dq_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, char_code, end_of_text, input ready);
   modport sink   (input valid, char_code, end_of_text, output ready);

endinterface

// ===== rtl/ipv4dq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_rsp_if
// Result channel: parsed address and its valid flag, one transfer per string.
// ----------------------------------------------------------------------------
interface ipv4dq_rsp_if import ipv4dq_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;
   logic              valid_res;

   modport source (output valid, address, valid_res, input ready);
   modport sink   (input valid, address, valid_res, output ready);

endinterface

// ===== rtl/ipv4_dotted_quad_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_top
// Parses a dotted-decimal IPv4 address from a stream of text characters.
// ----------------------------------------------------------------------------
// Usage
//  - req_if carries one character per transfer; end_of_text marks the final
//    character of a string. Leading and trailing whitespace is allowed.
//  - rsp_if carries one result per string, produced for the end-marked
//    character: the 32-bit address (first octet in bits 31..24) and
//    valid_res. An ill-formed string gives address 0 and valid_res 0.
//  - Throughput: one character per cycle, unless an end-marked character
//    waits on a full result register. The parse state update is a single
//    shallow step (digit times ten plus digit, compare to 255).
//  - Path: a character waits in the input register; the result for an
//    end-marked character moves on to the output register, then to rsp_if.
//  - A stalled receiver holds the result register; characters that do not
//    end a string keep flowing, and the input register only waits when an
//    end-marked character finds the result register still full.
//  - Synchronous reset empties both registers and returns the parser to
//    leading whitespace; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser_top import ipv4dq_pkg::*; (
   input logic          clock,
   input logic          reset,
   ipv4dq_req_if.sink   req_if,
   ipv4dq_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_OCTET,
      PH_TRAIL
   } phase_type;

   // input register
   logic              s1_valid_ff;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_eot_ff;

   // parse state
   phase_type          phase_ff,    phase_in;
   logic [1:0]         octet_idx_ff, octet_idx_in;
   logic [1:0]         digit_cnt_ff, digit_cnt_in;
   logic [OCTET_W-1:0] octet_val_ff, octet_val_in;
   logic [23:0]        addr_acc_ff,  addr_acc_in;
   logic               failed_ff,    failed_in;

   // result register
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_ok_ff,   rsp_ok_in;

   logic               out_free;
   logic               s1_go;
   logic               req_fire;
   logic               ch_space;
   logic               ch_digit;
   logic [3:0]         digit_val;
   logic [13:0]        prod_full;
   logic [OCTET_W-1:0] prod;

   // handshake
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_go        = s1_valid_ff && (!s1_eot_ff || out_free);
   assign req_if.ready = !s1_valid_ff || s1_go;
   assign req_fire     = req_if.valid && req_if.ready;

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.address   = rsp_addr_ff;
   assign rsp_if.valid_res = rsp_ok_ff;

   // character classes and decimal accumulate
   assign ch_space  = is_space(s1_char_ff);
   assign ch_digit  = is_digit(s1_char_ff);
   assign digit_val = s1_char_ff[3:0];
   assign prod_full = {1'b0, octet_val_ff, 3'b000} + {3'b000, octet_val_ff, 1'b0}
                    + {10'd0, digit_val};
   assign prod      = prod_full[OCTET_W-1:0];

   // next parse state for the character in the input register
   always_comb begin
      phase_in     = phase_ff;
      octet_idx_in = octet_idx_ff;
      digit_cnt_in = digit_cnt_ff;
      octet_val_in = octet_val_ff;
      addr_acc_in  = addr_acc_ff;
      failed_in    = failed_ff;
      if (!failed_ff) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (ch_digit) begin
                  phase_in     = PH_OCTET;
                  digit_cnt_in = 2'd1;
                  octet_val_in = {6'd0, digit_val};
               end else if (!ch_space) begin
                  failed_in = 1'b1;
               end
            end
            PH_OCTET: begin
               priority if (ch_digit) begin
                  if (digit_cnt_ff >= MAX_DIGITS) begin
                     failed_in = 1'b1;
                  end else begin
                     digit_cnt_in = digit_cnt_ff + 2'd1;
                     octet_val_in = prod;
                     if (prod > OCTET_MAX) failed_in = 1'b1;
                  end
               end else if (s1_char_ff == CHAR_DOT) begin
                  if (digit_cnt_ff == 2'd0 || octet_idx_ff == LAST_OCTET) begin
                     failed_in = 1'b1;
                  end else begin
                     addr_acc_in  = {addr_acc_ff[15:0], octet_val_ff[7:0]};
                     octet_idx_in = octet_idx_ff + 2'd1;
                     digit_cnt_in = 2'd0;
                     octet_val_in = '0;
                  end
               end else if (ch_space && octet_idx_ff == LAST_OCTET
                            && digit_cnt_ff != 2'd0) begin
                  phase_in = PH_TRAIL;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_TRAIL: begin
               if (!ch_space) failed_in = 1'b1;
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end
   end

   // result for an end-marked character
   always_comb begin
      rsp_ok_in = !failed_in && octet_idx_in == LAST_OCTET
               && octet_val_in <= OCTET_MAX
               && ((phase_in == PH_OCTET && digit_cnt_in != 2'd0)
                   || phase_in == PH_TRAIL);
      rsp_addr_in = rsp_ok_in ? {addr_acc_in, octet_val_in[7:0]} : '0;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LEAD;
         octet_idx_ff <= '0;
         digit_cnt_ff <= '0;
         octet_val_ff <= '0;
         addr_acc_ff  <= '0;
         failed_ff    <= 1'b0;
      end else begin
         // input register
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            s1_char_ff  <= req_if.char_code;
            s1_eot_ff   <= req_if.end_of_text;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end

         // parse state, cleared after the last character
         if (s1_go) begin
            if (s1_eot_ff) begin
               phase_ff     <= PH_LEAD;
               octet_idx_ff <= '0;
               digit_cnt_ff <= '0;
               octet_val_ff <= '0;
               addr_acc_ff  <= '0;
               failed_ff    <= 1'b0;
            end else begin
               phase_ff     <= phase_in;
               octet_idx_ff <= octet_idx_in;
               digit_cnt_ff <= digit_cnt_in;
               octet_val_ff <= octet_val_in;
               addr_acc_ff  <= addr_acc_in;
               failed_ff    <= failed_in;
            end
         end

         // result register
         if (s1_go && s1_eot_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_addr_ff  <= rsp_addr_in;
            rsp_ok_ff    <= rsp_ok_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // checks
   a_bad_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_addr_ff == '0)
      else $error("invalid result carries a non-zero address");

   a_last_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_eot_ff |=> rsp_valid_ff)
      else $error("end-marked character produced no result");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_eot_ff |=> phase_ff == PH_LEAD && !failed_ff
                              && octet_idx_ff == 2'd0 && digit_cnt_ff == 2'd0)
      else $error("parse state not cleared after end of text");

   a_octet_in_range: assert property (@(posedge clock) disable iff (reset)
      !failed_ff && phase_ff == PH_OCTET |-> octet_val_ff <= OCTET_MAX)
      else $error("octet value above limit without error");

   a_lead_clean: assert property (@(posedge clock) disable iff (reset)
      !failed_ff && phase_ff == PH_LEAD |-> octet_idx_ff == 2'd0 && addr_acc_ff == '0)
      else $error("leading phase with octets already taken");

endmodule

// ===== sim/ipv4_dotted_quad_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_top_test
// Streams character strings into the dotted-quad parser and checks every
// result against a cycle-free parse model kept in the bench. Directed
// strings cover the octet extremes and each kind of malformed text; random
// strings (well-formed, mangled and pure noise) follow, with random idle
// bursts on both channels and a final stretch at full rate.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser_top_test;
   import ipv4dq_pkg::*;

   localparam int RANDOM_ITEMS    = 1440;
   localparam int FULL_RATE_ITEMS = 150;
   localparam int IDLE_LIMIT      = 1000;
   localparam int SETTLE_CYCLES   = 8;

   typedef logic [CHAR_W-1:0] text_type[$];

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              valid_res;
   } quad_result_type;

   typedef enum logic [1:0] {
      SCAN_LEAD,
      SCAN_OCTET,
      SCAN_TRAIL
   } scan_phase_type;

   logic clock;
   logic reset;

   ipv4dq_req_if req_ch ();
   ipv4dq_rsp_if rsp_ch ();

   ipv4_dotted_quad_parser_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // parse state of the bench model
   scan_phase_type     scan_phase;
   logic [1:0]         octet_idx;
   logic [1:0]         digits_seen;
   logic [OCTET_W-1:0] octet_acc;
   logic [23:0]        upper_octets;
   logic               quad_bad;

   quad_result_type expected_quads[$];
   int              mismatch_count;
   bit              sender_idles;
   bit              receiver_stalls;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic logic blank_char(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic numeral_char(input logic [CHAR_W-1:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic void clear_parse();
      scan_phase   = SCAN_LEAD;
      octet_idx    = '0;
      digits_seen  = '0;
      octet_acc    = '0;
      upper_octets = '0;
      quad_bad     = 1'b0;
   endfunction

   // advance the model by one character and queue the address on the end mark
   function automatic void parse_char(input logic [CHAR_W-1:0] c, input logic last);
      quad_result_type got;
      logic            ok;
      if (!quad_bad) begin
         case (scan_phase)
            SCAN_LEAD: begin
               if (numeral_char(c)) begin
                  scan_phase  = SCAN_OCTET;
                  digits_seen = 2'd1;
                  octet_acc   = OCTET_W'(c - CHAR_ZERO);
               end else if (!blank_char(c)) begin
                  quad_bad = 1'b1;
               end
            end
            SCAN_OCTET: begin
               if (numeral_char(c)) begin
                  if (digits_seen >= MAX_DIGITS) begin
                     quad_bad = 1'b1;
                  end else begin
                     digits_seen = digits_seen + 2'd1;
                     octet_acc   = octet_acc * 10'd10 + OCTET_W'(c - CHAR_ZERO);
                     if (octet_acc > OCTET_MAX) quad_bad = 1'b1;
                  end
               end else if (c == CHAR_DOT) begin
                  if (digits_seen == 2'd0 || octet_idx >= LAST_OCTET) begin
                     quad_bad = 1'b1;
                  end else begin
                     upper_octets = {upper_octets[15:0], octet_acc[7:0]};
                     octet_idx    = octet_idx + 2'd1;
                     digits_seen  = '0;
                     octet_acc    = '0;
                  end
               end else if (blank_char(c) && octet_idx == LAST_OCTET
                            && digits_seen != 2'd0) begin
                  scan_phase = SCAN_TRAIL;
               end else begin
                  quad_bad = 1'b1;
               end
            end
            default: begin
               if (!blank_char(c)) quad_bad = 1'b1;
            end
         endcase
      end
      if (last) begin
         ok = !quad_bad && octet_idx == LAST_OCTET && octet_acc <= OCTET_MAX
              && ((scan_phase == SCAN_OCTET && digits_seen != 2'd0)
                  || scan_phase == SCAN_TRAIL);
         got.address   = ok ? {upper_octets, octet_acc[7:0]} : '0;
         got.valid_res = ok;
         expected_quads.push_back(got);
         clear_parse();
      end
   endfunction

   // one character transfer, with an optional idle burst ahead of it
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
      if (sender_idles && $urandom_range(0, 99) < 8) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.char_code   <= c;
      req_ch.end_of_text <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parse_char(c, last);
   endtask

   task automatic send_text(input text_type t);
      foreach (t[i]) send_char(t[i], i == t.size() - 1);
   endtask

   function automatic text_type to_bytes(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   // hold the sender off until every pending address has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_quads.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] random_blank();
      case ($urandom_range(0, 5))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_CR;
         default: return CHAR_W'($urandom_range(CHAR_TAB, CHAR_CR));
      endcase
   endfunction

   // digits, dots and blanks are favoured so that noise still hits the parse
   function automatic logic [CHAR_W-1:0] rough_char();
      case ($urandom_range(0, 3))
         0:       return CHAR_W'($urandom_range(CHAR_ZERO, CHAR_NINE));
         1:       return CHAR_DOT;
         2:       return random_blank();
         default: return CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   // well-formed dotted quad, random padding and leading zeros
   function automatic text_type make_quad();
      text_type t;
      int       v;
      int       need;
      int       total;
      int       scale;
      repeat ($urandom_range(0, 2)) t.push_back(random_blank());
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 255;
            default: v = $urandom_range(0, 255);
         endcase
         need  = v >= 100 ? 3 : (v >= 10 ? 2 : 1);
         total = $urandom_range(0, 3) == 0 ? $urandom_range(need, 3) : need;
         for (int d = total - 1; d >= 0; d--) begin
            scale = d == 2 ? 100 : (d == 1 ? 10 : 1);
            t.push_back(CHAR_ZERO + CHAR_W'((v / scale) % 10));
         end
         if (k != 3) t.push_back(CHAR_DOT);
      end
      repeat ($urandom_range(0, 2)) t.push_back(random_blank());
      return t;
   endfunction

   // one replaced, inserted or dropped character
   function automatic text_type mangle(input text_type t);
      int at;
      at = $urandom_range(0, t.size() - 1);
      case ($urandom_range(0, 2))
         0:       t[at] = rough_char();
         1:       t.insert(at, rough_char());
         default: if (t.size() > 1) t.delete(at);
      endcase
      return t;
   endfunction

   function automatic text_type make_noise();
      text_type t;
      repeat ($urandom_range(1, 10)) t.push_back(rough_char());
      return t;
   endfunction

   task automatic test_address_extremes();
      send_text(to_bytes("255.255.255.255"));
      send_text(to_bytes("0.0.0.0"));
      send_text(to_bytes("010.001.00.9"));
      send_text(to_bytes("\t\n\013\014\r 1.2.3.4 \r\n"));
   endtask

   task automatic test_blank_handling();
      send_text(to_bytes(" "));
      send_text(to_bytes("\t \r"));
      send_text(to_bytes("1. 2.3.4"));
      send_text(to_bytes("1.2.3.4 x"));
   endtask

   task automatic test_malformed_strings();
      text_type t;
      send_text(to_bytes("1.2.3.0001"));
      send_text(to_bytes("256.1.1.1"));
      send_text(to_bytes("1.2.3.999"));
      send_text(to_bytes("1..2.3.4"));
      send_text(to_bytes("1.2.3.4."));
      send_text(to_bytes(".1.2.3.4"));
      send_text(to_bytes("1.2.3"));
      send_text(to_bytes("1.2.3.a"));
      send_text(to_bytes("x1.2.3.4"));
      // zero byte inside the text and as the whole text
      t = to_bytes("1.2.3.4");
      t.insert(3, 8'h00);
      send_text(t);
      t = {8'h00};
      send_text(t);
      // top-bit byte after a complete quad
      t = to_bytes("1.2.3.4");
      t.push_back(8'hFF);
      send_text(t);
   endtask

   task automatic test_random_strings();
      text_type t;
      int       sent;
      int       pick;
      bit       drained;
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)      t = make_quad();
         else if (pick < 85) t = mangle(make_quad());
         else                t = make_noise();
         send_text(t);
         sent += t.size();
         if (!drained && sent >= RANDOM_ITEMS / 2) begin
            drain_results();
            drained = 1'b1;
         end
      end
   endtask

   task automatic test_back_to_back_strings();
      text_type t;
      int       sent;
      sent = 0;
      while (sent < FULL_RATE_ITEMS) begin
         t = $urandom_range(0, 3) == 0 ? mangle(make_quad()) : make_quad();
         send_text(t);
         sent += t.size();
      end
   endtask

   // receiver pacing: random stall bursts while enabled
   initial begin : rsp_pacing
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 99) < 10) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // result check against the oldest pending address
   always @(posedge clock) begin : result_check
      quad_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_quads.size() == 0) begin
            report_mismatch($sformatf("unexpected result address %h valid_res %b",
                                      rsp_ch.address, rsp_ch.valid_res));
         end else begin
            want = expected_quads.pop_front();
            if (rsp_ch.address !== want.address)
               report_mismatch($sformatf("address %h, want %h",
                                         rsp_ch.address, want.address));
            if (rsp_ch.valid_res !== want.valid_res)
               report_mismatch($sformatf("valid_res %b, want %b for address %h",
                                         rsp_ch.valid_res, want.valid_res,
                                         want.address));
         end
      end
   end

   // watchdog: ends the run after too many cycles without any transfer
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("ipv4_dotted_quad_parser_top verification failed");
      $finish;
   end

   // test sequence
   initial begin
      mismatch_count     = 0;
      sender_idles       = 1'b1;
      receiver_stalls    = 1'b1;
      clear_parse();
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.char_code   <= '0;
      req_ch.end_of_text <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_address_extremes();
      test_blank_handling();
      test_malformed_strings();
      test_random_strings();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      test_back_to_back_strings();

      req_ch.valid <= 1'b0;
      while (expected_quads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ipv4_dotted_quad_parser_top verification clean");
      end else begin
         $display("ipv4_dotted_quad_parser_top verification failed");
      end
      $finish;
   end

endmodule

// ===== ipv4_dotted_quad_parser_top.f =====
rtl/ipv4dq_pkg.sv
rtl/ipv4dq_req_if.sv
rtl/ipv4dq_rsp_if.sv
rtl/ipv4_dotted_quad_parser_top.sv
sim/ipv4_dotted_quad_parser_top_test.sv
